/* design/line_frame_fragmenter_assert.svh */
// Assertion macros used by the line frame fragmenter back end.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef LINE_FRAME_FRAGMENTER_ASSERT_SVH
`define LINE_FRAME_FRAGMENTER_ASSERT_SVH

`ifndef SYNTHESIS
`define LFF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LFF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define LFF_ASSERT(name, prop, msg)
`define LFF_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

/* design/lff_pkg.sv */
`default_nettype none

package lff_pkg;

  localparam logic [7:0] DELIM_BYTE = 8'h0A;
  localparam logic [7:0] FLAG_START = 8'h01;
  localparam logic [7:0] FLAG_MORE  = 8'h02;
  localparam logic [7:0] FLAG_END   = 8'h04;

  // Output slots of one job, in emission order.
  localparam int NUM_SLOTS      = 8;
  localparam int SLOT_BYTE_SEQ  = 0;
  localparam int SLOT_BYTE_FLG  = 1;
  localparam int SLOT_BYTE_LEN  = 2;
  localparam int SLOT_BYTE      = 3;
  localparam int SLOT_DELIM_SEQ = 4;
  localparam int SLOT_DELIM_FLG = 5;
  localparam int SLOT_DELIM_LEN = 6;
  localparam int SLOT_DELIM     = 7;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] line_length;
    logic        byte_present;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic [7:0]           byte_flags;
    logic [7:0]           byte_len;
    logic                 byte_end;
    logic [7:0]           delim_flags;
    logic [NUM_SLOTS-1:0] mask;
  } job_t;

endpackage

`default_nettype wire

/* design/line_frame_fragmenter.sv */
`default_nettype none

// Line frame fragmenter. Each input transaction carries one byte of a text
// line with the line's total length; the block turns the first
// min(length, LINE_CAPACITY-1) bytes plus a newline delimiter into radio
// frames of at most MTU_BYTES payload bytes, each led by a sequence byte, a
// flags byte (bit 0 start, bit 1 more, bit 2 end) and a length byte. A
// transaction with byte_present low, or a zero length, sends a frame that
// holds only the delimiter. While enable is low, input transactions are
// accepted and dropped without any output. An input transaction produces
// zero to eight output transactions; the output side moves one byte per
// cycle while the receiver is ready. Each header adds three bytes and the
// delimiter one more, so the output falls behind whenever these fall due.
// The output byte emitter is the limiting unit. A four-entry job queue
// between the input classifier and the emitter absorbs header bursts, so
// inputs keep flowing while the output side is stalled until the queue
// fills. Jobs pass through the job queue; output bytes are registered.

module line_frame_fragmenter #(
  parameter int MTU_BYTES     = 29,
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lff_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lff_pkg::out_item_t      out_data_o
);
  import lff_pkg::*;

  // Depth of the job queue between the classifier and the emitter.
  localparam int QUEUE_DEPTH = 4;

  logic job_push, queue_full, head_valid, head_pop;
  job_t job_new, job_head;

  // The front end tracks the position within the line and within the
  // current chunk, and turns each transaction into a job: which header,
  // payload and delimiter slots to send, and their contents.
  lff_front #(
    .MTU_BYTES    (MTU_BYTES),
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_push),
    .job_o       (job_new),
    .job_ready_i (!queue_full)
  );

  // Jobs wait here so that output backpressure does not stall the input
  // until the queue is full.
  lff_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_new),
    .full_o      (queue_full),
    .valid_o     (head_valid),
    .head_o      (job_head),
    .pop_i       (head_pop)
  );

  // The back end walks the head job's slots one byte per cycle while the
  // receiver is ready; it owns the frame sequence counter: headers go in order.
  lff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (job_head),
    .job_pop_o   (head_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* design/lff_front.sv */
`default_nettype none

module lff_front #(
  parameter int MTU_BYTES     = 29,
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lff_pkg::in_item_t in_data_i,
  output logic                 job_valid_o,
  output lff_pkg::job_t        job_o,
  input  wire logic            job_ready_i
);
  import lff_pkg::*;

  localparam int NW = $clog2(LINE_CAPACITY);
  localparam int CW = $clog2(MTU_BYTES + 1);

  logic          enable_q;
  logic [15:0]   pos_q, pos_d;
  logic [CW-1:0] chunk_q, chunk_d;

  logic [NW-1:0] kept;
  logic          is_empty, has_byte, at_last, has_delim;
  logic [15:0]   remain;
  logic          more, chunk_last, byte_hdr, delim_hdr, accept, line_done;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o && enable_q;

  always_comb begin
    if (in_data_i.line_length < 16'(LINE_CAPACITY - 1)) begin
      kept = in_data_i.line_length[NW-1:0];
    end else begin
      kept = NW'(LINE_CAPACITY - 1);
    end
  end

  assign is_empty   = !in_data_i.byte_present || (kept == '0);
  assign has_byte   = !is_empty && (pos_q < 16'(kept));
  assign at_last    = !is_empty && (pos_q == 16'(kept) - 16'd1);
  assign has_delim  = is_empty || at_last;
  // Bytes left in the payload from this position on, delimiter included.
  assign remain     = 16'(kept) + 16'd1 - pos_q;
  assign more       = remain > 16'(MTU_BYTES);
  assign chunk_last = chunk_q == CW'(MTU_BYTES - 1);
  assign byte_hdr   = chunk_q == '0;
  assign delim_hdr  = is_empty || chunk_last;
  assign line_done  = ({1'b0, pos_q} + 17'd1) >= {1'b0, in_data_i.line_length};

  always_comb begin
    job_o.data_byte   = in_data_i.data_byte;
    job_o.byte_flags  = ((pos_q == '0) ? FLAG_START : 8'h00) | (more ? FLAG_MORE : FLAG_END);
    job_o.byte_len    = more ? 8'(MTU_BYTES) : remain[7:0];
    job_o.byte_end    = chunk_last;
    job_o.delim_flags = is_empty ? (FLAG_START | FLAG_END) : FLAG_END;
    job_o.mask        = {has_delim, {3{has_delim && delim_hdr}},
                         has_byte, {3{has_byte && byte_hdr}}};
  end

  assign job_valid_o = accept && (has_byte || has_delim);

  always_comb begin
    pos_d   = pos_q;
    chunk_d = chunk_q;
    if (accept) begin
      if (is_empty || line_done) begin
        pos_d   = '0;
        chunk_d = '0;
      end else begin
        pos_d   = pos_q + 16'd1;
        chunk_d = chunk_last ? '0 : chunk_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      pos_q    <= '0;
      chunk_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      pos_q   <= pos_d;
      chunk_q <= chunk_d;
    end
  end

endmodule

`default_nettype wire

/* design/lff_fifo.sv */
`default_nettype none

module lff_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lff_pkg::job_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  output lff_pkg::job_t      head_o,
  input  wire logic          pop_i
);
  import lff_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NC = $clog2(DEPTH + 1);

  job_t          entry_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NC-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = count_q == NC'(DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NC'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NC'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/lff_back.sv */
`default_nettype none

`include "line_frame_fragmenter_assert.svh"

module lff_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire lff_pkg::job_t job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output lff_pkg::out_item_t out_data_o
);
  import lff_pkg::*;

  logic [NUM_SLOTS-1:0] done_q, done_d, pending, pick;
  logic [7:0]           seq_q, seq_d;
  logic                 out_valid_q, load, emit, last;
  out_item_t            out_q, out_d;

  assign pending = job_i.mask & ~done_q;
  assign pick    = pending & (~pending + NUM_SLOTS'(1));
  assign last    = (pending & ~pick) == '0;
  assign load    = !out_valid_q || out_ready_i;
  assign emit    = load && job_valid_i;
  assign job_pop_o = emit && last;

  always_comb begin
    out_d             = '0;
    out_d.last_of_run = last;
    seq_d             = seq_q;
    if (pick[SLOT_BYTE_SEQ] || pick[SLOT_DELIM_SEQ]) begin
      out_d.out_byte    = seq_q;
      out_d.frame_start = 1'b1;
      seq_d             = seq_q + 8'd1;
    end else if (pick[SLOT_BYTE_FLG]) begin
      out_d.out_byte = job_i.byte_flags;
    end else if (pick[SLOT_BYTE_LEN]) begin
      out_d.out_byte = job_i.byte_len;
    end else if (pick[SLOT_BYTE]) begin
      out_d.out_byte  = job_i.data_byte;
      out_d.frame_end = job_i.byte_end;
    end else if (pick[SLOT_DELIM_FLG]) begin
      out_d.out_byte = job_i.delim_flags;
    end else if (pick[SLOT_DELIM_LEN]) begin
      out_d.out_byte = 8'd1;
    end else begin
      out_d.out_byte  = DELIM_BYTE;
      out_d.frame_end = 1'b1;
    end
    done_d = last ? '0 : (done_q | pick);
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
      seq_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= job_valid_i;
      end
      if (emit) begin
        done_q <= done_d;
        seq_q  <= seq_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LFF_ASSERT(a_pick_onehot, $onehot0(pick), "more than one slot selected")
  `LFF_ASSERT(a_no_empty_job, !job_valid_i || (pending != '0), "queued job has no slot left")
  `LFF_ASSERT_NEXT(a_done_clears, job_pop_o, done_q == '0, "slot progress not cleared on pop")

endmodule

`default_nettype wire

/* tb/sv/tb_line_frame_fragmenter.sv */
`timescale 1ns / 100ps

// Self-checking bench for the line frame fragmenter. A predictor inside the
// bench follows every accepted input transaction and queues the frame bytes
// the block must emit. A monitor pops that queue on each output transaction
// and compares it field by field.
module tb_line_frame_fragmenter;
  import lff_pkg::*;

  // Block geometry, passed to the instance so that the predictor and the
  // hardware always agree.
  localparam int MTU = 29;
  localparam int CAP = 64;

  // Cycles allowed after the last expected byte for the job queue and the
  // output register to drain completely.
  localparam int SETTLE_CYCLES = 16;
  // Length of the one long receiver hold-off that fills the job queue.
  localparam int LONG_HOLD_CYCLES = 300;
  // Worst correct run: about 420 input transactions, each with up to eight
  // output bytes behind a receiver stall plus a sender gap. The limit below
  // is meant to stop only a hung run.
  localparam longint TIMEOUT_NS = 64'd12_000_000;

  typedef enum logic [1:0] {
    ROW_ENABLE_OFF,
    ROW_ENABLE_ON,
    ROW_LINE_ITEM
  } row_op_e;

  // One row of the directed table. A typed_count of -1 means the row is
  // checked against the predictor; otherwise that many bytes are taken from
  // the list of hand-written results.
  typedef struct packed {
    row_op_e  op;
    in_item_t item;
    int       typed_count;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  // Predictor state: sequence byte of the next frame, position inside the
  // current line, and the enable register as last written.
  logic [7:0]  next_seq;
  logic [15:0] line_pos;
  logic        tx_enabled;

  out_item_t   expected_bytes[$];
  out_item_t   typed_bytes[$];
  stim_row_t   dir_rows[$];

  int unsigned mismatches;
  int          accepted_items;
  bit          burst_mode;
  bit          hold_off_req;

  line_frame_fragmenter #(
    .MTU_BYTES    (MTU),
    .LINE_CAPACITY(CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic out_item_t frame_byte(input logic [7:0] b, input logic fs,
                                           input logic fe, input logic lor);
    out_item_t r;
    r.out_byte    = b;
    r.frame_start = fs;
    r.frame_end   = fe;
    r.last_of_run = lor;
    return r;
  endfunction

  function automatic in_item_t line_item(input logic [7:0] b, input logic [15:0] len,
                                         input logic present);
    in_item_t r;
    r.data_byte    = b;
    r.line_length  = len;
    r.byte_present = present;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input row_op_e op, input in_item_t item,
                                       input int typed_count);
    stim_row_t r;
    r.op          = op;
    r.item        = item;
    r.typed_count = typed_count;
    return r;
  endfunction

  // Queues one payload byte at offset idx of a payload plen bytes long. When
  // the byte opens a chunk, the three header bytes of that chunk go first.
  function automatic void push_payload(input int idx, input int plen, input logic [7:0] b);
    int         chunk;
    logic [7:0] flags;
    if (idx % MTU == 0) begin
      chunk = (plen - idx > MTU) ? MTU : plen - idx;
      flags = (idx == 0) ? FLAG_START : 8'h00;
      flags |= (idx + chunk < plen) ? FLAG_MORE : FLAG_END;
      expected_bytes.push_back(frame_byte(next_seq, 1'b1, 1'b0, 1'b0));
      next_seq++;
      expected_bytes.push_back(frame_byte(flags, 1'b0, 1'b0, 1'b0));
      expected_bytes.push_back(frame_byte(8'(chunk), 1'b0, 1'b0, 1'b0));
    end
    expected_bytes.push_back(frame_byte(b, 1'b0,
                                        ((idx + 1) % MTU == 0) || (idx + 1 == plen), 1'b0));
  endfunction

  // Works out the frame bytes caused by one accepted input transaction and
  // advances the line position and the sequence counter.
  function automatic void predict_frames(input in_item_t item);
    int first;
    int kept;
    int plen;
    int p;
    if (!tx_enabled) return;
    first = expected_bytes.size();
    kept  = (int'(item.line_length) < CAP - 1) ? int'(item.line_length) : CAP - 1;
    if (!item.byte_present || kept == 0) begin
      // Empty line: a lone delimiter frame, and any line in progress is dropped.
      push_payload(0, 1, DELIM_BYTE);
      line_pos = 16'd0;
    end else begin
      plen = kept + 1;
      p    = int'(line_pos);
      // Bytes past the capacity fall through without any output.
      if (p < kept) push_payload(p, plen, item.data_byte);
      // The delimiter follows the last kept byte in the same run.
      if (p == kept - 1) push_payload(kept, plen, DELIM_BYTE);
      line_pos = (p + 1 >= int'(item.line_length)) ? 16'd0 : 16'(p + 1);
    end
    if (expected_bytes.size() > first) expected_bytes[$].last_of_run = 1'b1;
  endfunction

  // Most gaps are zero or short, a few are long; burst phases have none.
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Line lengths lean on the chunk and capacity boundaries: 28 and 29 kept
  // bytes put the delimiter at the end of a chunk or alone in a new one, and
  // 62 to 64 straddle the capacity.
  function automatic int pick_line_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(1, 8);
    if (r < 60) return $urandom_range(9, 30);
    if (r < 75) return 27 + $urandom_range(0, 3) + MTU * $urandom_range(0, 1);
    if (r < 92) return $urandom_range(60, 66);
    return $urandom_range(67, 90);
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return DELIM_BYTE;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void report_mismatch(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, field, want, got);
  endfunction

  // Offers one input transaction after a random gap and holds it until it is
  // accepted. Valid is only lowered when a gap really follows, so a
  // back-to-back transaction never sees two assignments in one time step.
  task automatic offer(input in_item_t item, input int typed_count);
    int gap;
    int depth0;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    depth0 = expected_bytes.size();
    if (tx_enabled) accepted_items++;
    predict_frames(item);
    // Hand-written rows replace what the predictor queued, while the
    // predictor state still moves on.
    if (typed_count >= 0) begin
      while (expected_bytes.size() > depth0) void'(expected_bytes.pop_back());
      repeat (typed_count) expected_bytes.push_back(typed_bytes.pop_front());
    end
  endtask

  task automatic wait_for_results();
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The register is only written once the block has gone quiet.
  task automatic set_enable(input logic value);
    in_valid_i <= 1'b0;
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tx_enabled = value;
  endtask

  // Random lines. Most are well formed with random content; the rest are
  // empty lines, lines cut short and lines whose length changes midway. Every
  // kind ends with the line position back at zero.
  task automatic send_random_lines(input int budget, input bit with_pressure);
    int start;
    int mode;
    int len;
    int len2;
    int k;
    bit held;
    bit paused;
    start  = accepted_items;
    held   = 1'b0;
    paused = 1'b0;
    while (accepted_items - start < budget) begin
      // A third of the way in, the receiver holds off for a long stretch while
      // the sender keeps offering, so the job queue fills and input stalls.
      if (with_pressure && !held && accepted_items - start >= budget / 3) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      // Two thirds in, the sender pauses until every frame byte is out.
      if (with_pressure && !paused && accepted_items - start >= (2 * budget) / 3) begin
        in_valid_i <= 1'b0;
        wait_for_results();
        paused = 1'b1;
      end
      mode = $urandom_range(0, 99);
      if (mode < 65) begin
        len = pick_line_length();
        repeat (len) offer(line_item(rand_data(), 16'(len), 1'b1), -1);
      end else if (mode < 75) begin
        if ($urandom_range(0, 1))
          offer(line_item(rand_data(), 16'($urandom_range(0, 65535)), 1'b0), -1);
        else
          offer(line_item(rand_data(), 16'd0, 1'b1), -1);
      end else if (mode < 88) begin
        // Line cut short, then abandoned by an empty line or by a shorter
        // length that ends it at once.
        len = $urandom_range(0, 1) ? $urandom_range(2, 80) : $urandom_range(81, 65535);
        k   = $urandom_range(1, (len - 1 < 40) ? len - 1 : 40);
        repeat (k) offer(line_item(rand_data(), 16'(len), 1'b1), -1);
        if ($urandom_range(0, 1))
          offer(line_item(rand_data(), 16'($urandom_range(0, 65535)), 1'b0), -1);
        else
          offer(line_item(rand_data(), 16'($urandom_range(1, k)), 1'b1), -1);
      end else begin
        // Length grows midway; the line runs on until the new length ends it,
        // which can repeat or leave frames incomplete.
        len  = $urandom_range(2, 70);
        k    = $urandom_range(1, len - 1);
        len2 = $urandom_range(k + 1, 90);
        repeat (k) offer(line_item(rand_data(), 16'(len), 1'b1), -1);
        do offer(line_item(rand_data(), 16'(len2), 1'b1), -1); while (line_pos != 16'd0);
      end
    end
  endtask

  // Receiver: random stalls, and one long hold-off when asked for. The
  // hold-off length is counted here, not by the sender.
  initial begin : receiver
    int hold;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold         = LONG_HOLD_CYCLES;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Output check: every output transaction is matched against the oldest
  // expected frame byte.
  always @(posedge clk_i) begin : out_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output, expected nothing, actual byte 0x%02h %b%b%b",
                 $time, out_data_o.out_byte, out_data_o.frame_start,
                 out_data_o.frame_end, out_data_o.last_of_run);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data_o.out_byte !== want.out_byte)
          report_mismatch("out_byte", want.out_byte, out_data_o.out_byte);
        if (out_data_o.frame_start !== want.frame_start)
          report_mismatch("frame_start", 8'(want.frame_start), 8'(out_data_o.frame_start));
        if (out_data_o.frame_end !== want.frame_end)
          report_mismatch("frame_end", 8'(want.frame_end), 8'(out_data_o.frame_end));
        if (out_data_o.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 8'(want.last_of_run), 8'(out_data_o.last_of_run));
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_line_frame_fragmenter: FAIL");
    $finish;
  end

  initial begin : main_seq
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    next_seq       = 8'd0;
    line_pos       = 16'd0;
    tx_enabled     = 1'b0;
    mismatches     = 0;
    accepted_items = 0;
    burst_mode     = 1'b0;
    hold_off_req   = 1'b0;

    // Directed table. While disabled, even extreme fields give nothing.
    dir_rows.push_back(mk_row(ROW_ENABLE_OFF, '0, -1));
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'hFF, 16'hFFFF, 1'b1), 0));
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h00, 16'h0000, 1'b0), 0));
    dir_rows.push_back(mk_row(ROW_ENABLE_ON, '0, -1));
    // Empty line by a missing byte: a lone delimiter frame with sequence 0.
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'hFF, 16'd5, 1'b0), 4));
    typed_bytes.push_back(frame_byte(8'h00, 1'b1, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(FLAG_START | FLAG_END, 1'b0, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(8'd1, 1'b0, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(DELIM_BYTE, 1'b0, 1'b1, 1'b1));
    // Empty line by a zero length.
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h00, 16'd0, 1'b1), 4));
    typed_bytes.push_back(frame_byte(8'h01, 1'b1, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(FLAG_START | FLAG_END, 1'b0, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(8'd1, 1'b0, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(DELIM_BYTE, 1'b0, 1'b1, 1'b1));
    // One-byte line: header, the byte and the delimiter in a single run.
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'hFF, 16'd1, 1'b1), 5));
    typed_bytes.push_back(frame_byte(8'h02, 1'b1, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(FLAG_START | FLAG_END, 1'b0, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(8'd2, 1'b0, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(8'hFF, 1'b0, 1'b0, 1'b0));
    typed_bytes.push_back(frame_byte(DELIM_BYTE, 1'b0, 1'b1, 1'b1));
    // Longest length opens a multi-chunk frame, then a shorter length ends
    // the line with no output at all.
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'hA5, 16'hFFFF, 1'b1), -1));
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h5A, 16'hFFFF, 1'b1), -1));
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h11, 16'd2, 1'b1), -1));
    // Short complete line.
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h01, 16'd3, 1'b1), -1));
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h02, 16'd3, 1'b1), -1));
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h03, 16'd3, 1'b1), -1));
    // Lengths with the top bit set and clear, then abandoned by an empty line.
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h00, 16'h8000, 1'b1), -1));
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h0A, 16'h7FFF, 1'b1), -1));
    dir_rows.push_back(mk_row(ROW_LINE_ITEM, line_item(8'h77, 16'd1, 1'b0), -1));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_ENABLE_OFF: set_enable(1'b0);
        ROW_ENABLE_ON:  set_enable(1'b1);
        default:        offer(dir_rows[i].item, dir_rows[i].typed_count);
      endcase
    end

    // Random lines with the long hold-off and the sender pause.
    send_random_lines(120, 1'b1);

    // Disabled: random transactions are swallowed and leave the state alone.
    set_enable(1'b0);
    repeat (30) begin
      offer(line_item(rand_data(), 16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1))), -1);
    end

    // Back on, with both sides running without gaps.
    set_enable(1'b1);
    burst_mode = 1'b1;
    send_random_lines(100, 1'b0);
    burst_mode = 1'b0;

    // A quick off/on toggle must not disturb the sequence counter.
    set_enable(1'b0);
    set_enable(1'b1);
    send_random_lines(100, 1'b0);

    in_valid_i <= 1'b0;
    wait_for_results();
    if (mismatches == 0) begin
      $display("tb_line_frame_fragmenter: PASS");
    end else begin
      $display("tb_line_frame_fragmenter: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/lff_pkg.sv
design/lff_front.sv
design/lff_fifo.sv
design/lff_back.sv
design/line_frame_fragmenter.sv
tb/sv/tb_line_frame_fragmenter.sv
